@@ rtl/sha1md_pkg.sv @@
// shared types and constants for the sha-1 digest block
package sha1md_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  localparam int unsigned NumWords  = 5;
  localparam int unsigned WinWords  = 16;
  localparam int unsigned CntW      = 61;
  localparam int unsigned RoundW    = 7;
  localparam int unsigned IdxW      = 3;

  localparam logic [RoundW-1:0] LastRound = RoundW'(79);
  localparam logic [RoundW-1:0] Phase1    = RoundW'(20);
  localparam logic [RoundW-1:0] Phase2    = RoundW'(40);
  localparam logic [RoundW-1:0] Phase3    = RoundW'(60);
  localparam logic [IdxW-1:0]   LastIdx   = IdxW'(4);

  localparam logic [5:0] LastFill = 6'd63;
  localparam logic [7:0] PadByte  = 8'h80;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t H0Init = 32'h67452301;
  localparam word_t H1Init = 32'hEFCDAB89;
  localparam word_t H2Init = 32'h98BADCFE;
  localparam word_t H3Init = 32'h10325476;
  localparam word_t H4Init = 32'hC3D2E1F0;

endpackage

@@ rtl/sha1md_round.sv @@
// one sha-1 round and one message schedule step
module sha1md_round (
  input  logic [sha1md_pkg::RoundW-1:0] round_i,
  input  sha1md_pkg::work_t             work_i,
  input  sha1md_pkg::word_t             w0_i,
  input  sha1md_pkg::word_t             w2_i,
  input  sha1md_pkg::word_t             w8_i,
  input  sha1md_pkg::word_t             w13_i,
  output sha1md_pkg::work_t             work_o,
  output sha1md_pkg::word_t             wnew_o
);

  sha1md_pkg::word_t f;
  sha1md_pkg::word_t k;
  sha1md_pkg::word_t t;
  sha1md_pkg::word_t x;

  always_comb begin
    if (round_i < sha1md_pkg::Phase1) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = sha1md_pkg::K0;
    end else if (round_i < sha1md_pkg::Phase2) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1md_pkg::K1;
    end else if (round_i < sha1md_pkg::Phase3) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = sha1md_pkg::K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1md_pkg::K3;
    end
  end

  assign t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w0_i;

  assign work_o.a = t;
  assign work_o.b = work_i.a;
  assign work_o.c = {work_i.b[1:0], work_i.b[31:2]};
  assign work_o.d = work_i.c;
  assign work_o.e = work_i.d;

  assign x      = w13_i ^ w8_i ^ w2_i ^ w0_i;
  assign wnew_o = {x[30:0], x[31]};

endmodule

@@ rtl/sha1_message_digest.sv @@
// sha-1 digest of a byte stream, top level
//
//  channel  direction  handshake                 payload
//  input    in         start_i, busy_o           msg_byte_i, has_byte_i, last_i
//  result   out        digest_valid_o (strobe)   digest_word_o, word_index_o, last_word_o
//
// a message byte is shifted into the block window; the 64th byte of a block starts
// the rounds on the single round unit and then a fold into the chain words, and no
// new byte is taken until they are done. a last transaction feeds 0x80, zero fill
// and the length through the same byte path (one or two final blocks), then drives
// the five digest words on consecutive cycles.
// reset clears the sequencer and byte count and loads the initial chain words; no clearing pass.
// results cannot be stalled; busy_o stays high until the last digest word.
module sha1_message_digest (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [7:0]                    msg_byte_i,
  input  logic                          has_byte_i,
  input  logic                          last_i,
  output logic                          digest_valid_o,
  output logic [31:0]                   digest_word_o,
  output logic [sha1md_pkg::IdxW-1:0]   word_index_o,
  output logic                          last_word_o
);

  sha1md_pkg::state_e state_q, state_d;

  logic [5:0]                      fill_q;
  logic [sha1md_pkg::CntW-1:0]     cnt_q;
  logic [sha1md_pkg::RoundW-1:0]   round_q;
  logic [sha1md_pkg::IdxW-1:0]     idx_q;
  logic                            pad_q;
  logic                            first_q;
  logic                            wrap_q;
  logic                            final_q;

  sha1md_pkg::word_t win_q   [sha1md_pkg::WinWords];
  sha1md_pkg::word_t chain_q [sha1md_pkg::NumWords];
  sha1md_pkg::work_t work_q;
  sha1md_pkg::work_t work_nxt;
  sha1md_pkg::word_t wnew;
  sha1md_pkg::work_t chain_work;

  logic        accept;
  logic        shift_en;
  logic        blk_full;
  logic        len_phase;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  in_byte;

  assign accept    = start_i && (state_q == sha1md_pkg::ST_IDLE);
  assign shift_en  = (accept && has_byte_i) || (state_q == sha1md_pkg::ST_PAD);
  assign blk_full  = shift_en && (fill_q == sha1md_pkg::LastFill);
  assign len_phase = !first_q && !wrap_q && (fill_q[5:3] == 3'b111);
  assign bit_len   = {cnt_q, 3'b000};
  assign len_byte  = 8'(bit_len >> {~fill_q[2:0], 3'b000});
  assign pad_byte  = first_q ? sha1md_pkg::PadByte : (len_phase ? len_byte : 8'h00);
  assign in_byte   = (state_q == sha1md_pkg::ST_PAD) ? pad_byte : msg_byte_i;

  assign chain_work = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
                        d: chain_q[3], e: chain_q[4]};

  sha1md_round u_round (
    .round_i (round_q),
    .work_i  (work_q),
    .w0_i    (win_q[0]),
    .w2_i    (win_q[2]),
    .w8_i    (win_q[8]),
    .w13_i   (win_q[13]),
    .work_o  (work_nxt),
    .wnew_o  (wnew)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (accept) begin
          if (blk_full) begin
            state_d = sha1md_pkg::ST_ROUND;
          end else if (last_i) begin
            state_d = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (blk_full) begin
          state_d = sha1md_pkg::ST_ROUND;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (round_q == sha1md_pkg::LastRound) begin
          state_d = sha1md_pkg::ST_FOLD;
        end
      end
      sha1md_pkg::ST_FOLD: begin
        if (final_q) begin
          state_d = sha1md_pkg::ST_EMIT;
        end else if (pad_q) begin
          state_d = sha1md_pkg::ST_PAD;
        end else begin
          state_d = sha1md_pkg::ST_IDLE;
        end
      end
      sha1md_pkg::ST_EMIT: begin
        if (idx_q == sha1md_pkg::LastIdx) begin
          state_d = sha1md_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1md_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o         = (state_q != sha1md_pkg::ST_IDLE);
    digest_valid_o = (state_q == sha1md_pkg::ST_EMIT);
    word_index_o   = idx_q;
    last_word_o    = digest_valid_o && (idx_q == sha1md_pkg::LastIdx);
    case (idx_q)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      default: digest_word_o = chain_q[4];
    endcase
  end

  // control and chain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1md_pkg::ST_IDLE;
      fill_q     <= '0;
      cnt_q      <= '0;
      round_q    <= '0;
      idx_q      <= '0;
      pad_q      <= 1'b0;
      first_q    <= 1'b0;
      wrap_q     <= 1'b0;
      final_q    <= 1'b0;
      chain_q[0] <= sha1md_pkg::H0Init;
      chain_q[1] <= sha1md_pkg::H1Init;
      chain_q[2] <= sha1md_pkg::H2Init;
      chain_q[3] <= sha1md_pkg::H3Init;
      chain_q[4] <= sha1md_pkg::H4Init;
    end else begin
      state_q <= state_d;
      if (shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (blk_full) begin
        round_q <= '0;
      end
      case (state_q)
        sha1md_pkg::ST_IDLE: begin
          if (accept) begin
            pad_q   <= last_i;
            first_q <= last_i;
            wrap_q  <= 1'b0;
            final_q <= 1'b0;
            if (has_byte_i) begin
              cnt_q <= cnt_q + sha1md_pkg::CntW'(1);
            end
          end
        end
        sha1md_pkg::ST_PAD: begin
          first_q <= 1'b0;
          if (first_q) begin
            wrap_q <= (fill_q[5:3] == 3'b111);
          end
          if (blk_full && len_phase) begin
            final_q <= 1'b1;
          end
        end
        sha1md_pkg::ST_ROUND: begin
          round_q <= round_q + sha1md_pkg::RoundW'(1);
        end
        sha1md_pkg::ST_FOLD: begin
          wrap_q     <= 1'b0;
          idx_q      <= '0;
          chain_q[0] <= chain_q[0] + work_q.a;
          chain_q[1] <= chain_q[1] + work_q.b;
          chain_q[2] <= chain_q[2] + work_q.c;
          chain_q[3] <= chain_q[3] + work_q.d;
          chain_q[4] <= chain_q[4] + work_q.e;
        end
        sha1md_pkg::ST_EMIT: begin
          idx_q <= idx_q + sha1md_pkg::IdxW'(1);
          if (idx_q == sha1md_pkg::LastIdx) begin
            pad_q      <= 1'b0;
            final_q    <= 1'b0;
            cnt_q      <= '0;
            chain_q[0] <= sha1md_pkg::H0Init;
            chain_q[1] <= sha1md_pkg::H1Init;
            chain_q[2] <= sha1md_pkg::H2Init;
            chain_q[3] <= sha1md_pkg::H3Init;
            chain_q[4] <= sha1md_pkg::H4Init;
          end
        end
        default: ;
      endcase
    end
  end

  // byte buffer doubling as schedule window, and working words
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < sha1md_pkg::WinWords - 1; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[sha1md_pkg::WinWords-1] <= {win_q[sha1md_pkg::WinWords-1][23:0], in_byte};
    end else if (state_q == sha1md_pkg::ST_ROUND) begin
      for (int i = 0; i < sha1md_pkg::WinWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sha1md_pkg::WinWords-1] <= wnew;
    end
    if (blk_full) begin
      work_q <= chain_work;
    end else if (state_q == sha1md_pkg::ST_ROUND) begin
      work_q <= work_nxt;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o |-> busy_o)
    else $error("digest strobe while not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_word_o |-> (digest_valid_o && (word_index_o == sha1md_pkg::LastIdx)))
    else $error("last word flag without fifth digest word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_word_o |=> !busy_o)
    else $error("block stays busy after final digest word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("closing transaction did not start padding");

endmodule

@@ dv/tb_sha1_message_digest.sv @@
// self-checking testbench for the streaming sha-1 digest block
`timescale 1ns / 100ps

module tb_sha1_message_digest;

  localparam int CycleLimit = 400000;
  localparam int RandomItems = 250;

  typedef struct {
    sha1md_pkg::word_t               word;
    logic [sha1md_pkg::IdxW-1:0]     idx;
    logic                            last_w;
  } digest_exp_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [7:0]                  msg_byte_i;
  logic                        has_byte_i;
  logic                        last_i;
  logic                        digest_valid_o;
  logic [31:0]                 digest_word_o;
  logic [sha1md_pkg::IdxW-1:0] word_index_o;
  logic                        last_word_o;

  logic [7:0]                  msg_buf [64];
  sha1md_pkg::word_t           chain_h [sha1md_pkg::NumWords];
  logic [sha1md_pkg::CntW-1:0] byte_cnt;
  digest_exp_t digest_q [$];
  digest_exp_t seen_exp;
  int          err_cnt;
  int          cycle_cnt;
  int          item_cnt;
  bit          no_gaps;

  sha1_message_digest DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .msg_byte_i     (msg_byte_i),
    .has_byte_i     (has_byte_i),
    .last_i         (last_i),
    .digest_valid_o (digest_valid_o),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void load_init_chain();
    chain_h[0] = sha1md_pkg::H0Init;
    chain_h[1] = sha1md_pkg::H1Init;
    chain_h[2] = sha1md_pkg::H2Init;
    chain_h[3] = sha1md_pkg::H3Init;
    chain_h[4] = sha1md_pkg::H4Init;
    byte_cnt = '0;
  endfunction

  function automatic void compress_buffer();
    sha1md_pkg::word_t w [16];
    sha1md_pkg::word_t a, b, c, d, e, f, k, t, x;
    int s;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      s = r & 15;
      if (r >= 16) begin
        x = w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s];
        w[s] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[s];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void predict_item(logic [7:0] b, logic h, logic l);
    int pos;
    logic [63:0] bits;
    digest_exp_t exp_item;
    if (h) begin
      msg_buf[byte_cnt[5:0]] = b;
      byte_cnt = byte_cnt + 1'b1;
      if (byte_cnt[5:0] == 6'd0) compress_buffer();
    end
    if (!l) return;
    pos = int'(byte_cnt[5:0]);
    msg_buf[pos] = sha1md_pkg::PadByte;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_buf[pos] = 8'h00;
        pos++;
      end
      compress_buffer();
      pos = 0;
    end
    while (pos < 56) begin
      msg_buf[pos] = 8'h00;
      pos++;
    end
    bits = {byte_cnt, 3'b000};
    for (int i = 0; i < 8; i++) msg_buf[56 + i] = bits[63 - 8*i -: 8];
    compress_buffer();
    for (int i = 0; i < sha1md_pkg::NumWords; i++) begin
      exp_item.word   = chain_h[i];
      exp_item.idx    = i[sha1md_pkg::IdxW-1:0];
      exp_item.last_w = (i == sha1md_pkg::NumWords - 1);
      digest_q.insert(digest_q.size(), exp_item);
    end
    load_init_chain();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic h, input logic l);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    msg_byte_i <= b;
    has_byte_i <= h;
    last_i     <= l;
    do @(posedge clk_i); while (busy_o);
    predict_item(b, h, l);
    if (h || l) item_cnt++;
  endtask

  task automatic send_message(input int len, input bit close_apart);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !close_apart);
    end
    if (close_apart || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // empty message right after reset
  task automatic test_empty_message();
    send_item(8'hA5, 1'b0, 1'b1);
    wait_drained();
  endtask

  // idle items leave the running message untouched
  task automatic test_idle_items();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    wait_drained();
  endtask

  // one-byte messages at the byte extremes, a short text, a two-byte message and an empty one
  task automatic test_short_messages();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    no_gaps = 1'b1;
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    no_gaps = 1'b0;
    send_item(8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  // random messages, lengths weighted toward the padding boundaries
  task automatic test_random_messages();
    int stop_at;
    int len;
    int msg_cnt;
    stop_at = item_cnt + RandomItems;
    msg_cnt = 0;
    while (item_cnt < stop_at) begin
      case ($urandom_range(0, 9))
        0: len = 54 + $urandom_range(0, 3);
        1: len = 62 + $urandom_range(0, 4);
        2: len = 120 + $urandom_range(0, 8);
        default: len = $urandom_range(0, 12);
      endcase
      if (len > stop_at - item_cnt) len = stop_at - item_cnt;
      no_gaps = ($urandom_range(0, 3) == 0);
      send_message(len, 1'($urandom_range(0, 1)));
      msg_cnt++;
      if (msg_cnt == 6) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && digest_valid_o) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, got %h index %0d last %b",
                 $time, digest_word_o, word_index_o, last_word_o);
        err_cnt++;
      end else begin
        seen_exp = digest_q.pop_front();
        if (digest_word_o !== seen_exp.word) begin
          $display("%0t: digest_word mismatch, expected %h, got %h",
                   $time, seen_exp.word, digest_word_o);
          err_cnt++;
        end
        if (word_index_o !== seen_exp.idx) begin
          $display("%0t: word_index mismatch, expected %0d, got %0d",
                   $time, seen_exp.idx, word_index_o);
          err_cnt++;
        end
        if (last_word_o !== seen_exp.last_w) begin
          $display("%0t: last_word mismatch, expected %b, got %b",
                   $time, seen_exp.last_w, last_word_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    msg_byte_i = 8'h00;
    has_byte_i = 1'b0;
    last_i     = 1'b0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    item_cnt   = 0;
    no_gaps    = 1'b0;
    for (int i = 0; i < 64; i++) msg_buf[i] = 8'h00;
    load_init_chain();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_message();
    test_idle_items();
    test_short_messages();
    test_random_messages();

    wait_drained();
    repeat (400) @(posedge clk_i);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sha1md_pkg.sv
rtl/sha1md_round.sv
rtl/sha1_message_digest.sv
dv/tb_sha1_message_digest.sv
